// ===== hdl/ctc_pkg.sv =====
// Shared types and constants for the column truncation compressor.
`default_nettype none

package ctc_pkg;

    // Fixed field widths of the stream words and configuration port
    localparam int BIN_W      = 32;
    localparam int CODE_W     = 4;
    localparam int CNT_W      = 11;
    localparam int HEIGHT_W   = 11;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSION_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_HEIGHT  = 1'd1;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] HEIGHT_DEFAULT = 11'd256;

    // Result buffer geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // One result word, last field in the lowest bits
    typedef struct packed {
        logic                over_length;
        logic [CNT_W-1:0]    keep_count;
        logic [CNT_W-1:0]    keep_first;
        logic [CODE_W-1:0]   trunc_code;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/ctc_col_mem.sv =====
// Two column banks: one holds the reference column, the other takes the current one.
`default_nettype none

module ctc_col_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   rd_en,
    input  wire logic [AW-1:0]          rd_addr,
    output logic [ctc_pkg::BIN_W-1:0]   rd_data0,
    output logic [ctc_pkg::BIN_W-1:0]   rd_data1,
    input  wire logic                   wr_en,
    input  wire logic                   wr_bank,
    input  wire logic [AW-1:0]          wr_addr,
    input  wire logic [ctc_pkg::BIN_W-1:0] wr_data
);
    import ctc_pkg::*;

    logic [BIN_W-1:0] bank0_mem [DEPTH];
    logic [BIN_W-1:0] bank1_mem [DEPTH];
    logic [BIN_W-1:0] rd_data0_reg;
    logic [BIN_W-1:0] rd_data1_reg;

    // Bank 0: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data0_reg <= bank0_mem[rd_addr];
        end
    end

    // Bank 1: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en && wr_bank) begin
            bank1_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data1_reg <= bank1_mem[rd_addr];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

`default_nettype wire

// ===== hdl/ctc_out_fifo.sv =====
// Small result buffer between the decision stage and the result channel.
`default_nettype none

module ctc_out_fifo (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire ctc_pkg::result_t           push_data,
    input  wire logic                       pop,
    output ctc_pkg::result_t                head_data,
    output logic                            not_empty,
    output logic [ctc_pkg::FIFO_CW-1:0]     fill
);
    import ctc_pkg::*;

    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg;
    logic                 do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + FIFO_CW'(1);
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - FIFO_CW'(1);
            end
        end
    end

    assign head_data = fifo_mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign fill      = cnt_reg;

endmodule

`default_nettype wire

// ===== hdl/column_truncation_compressor_unit.sv =====
// Top level of the column truncation compressor.
`default_nettype none

// Takes spectrogram bins one word per clock, bottom bin first, with s_tlast on the
// last bin of a column, and returns one result word per column: the truncation code,
// the first bin to keep, the number of bins to keep and an over-length flag. The
// sustained rate is one bin per clock while the result buffer has room; a column's
// result goes through the compare and update stages. The column memory is two banks
// that are each read once and written once per clock, one holding the reference
// column and the other taking the current one, with the banks swapped instead of
// copied when a column is stored whole. The memory needs no clearing pass after
// reset. Write the configuration registers only while no column is in flight.
module column_truncation_compressor_unit #(
    parameter int MAX_BINS     = 1024,
    parameter int MAX_DISTANCE = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input bins
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ctc_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] bin_value
    input  wire logic                              s_tlast,   // column_end
    // Results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [3:0] trunc_code, [14:4] keep_first, [25:15] keep_count, [26] over_length
    output logic [ctc_pkg::M_TDATA_W-1:0]          m_tdata,
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ctc_pkg::*;

    localparam int PW    = $clog2(MAX_BINS + 1);
    localparam int AW    = $clog2(MAX_BINS);
    localparam int CMPW  = (PW > HEIGHT_W) ? PW : HEIGHT_W;
    localparam int DW    = $clog2(MAX_DISTANCE + 1);
    localparam int CODEW = (DW + 2 > CODE_W) ? DW + 2 : CODE_W;

    // Configuration registers
    logic                comp_on_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // Input side position tracking
    logic [PW-1:0] pos_reg;
    logic          over_reg;
    logic          acc;
    logic          in_rng;
    logic [PW-1:0] pos_inc;

    // Compare stage
    logic             s1_valid_reg;
    logic [BIN_W-1:0] s1_v_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_inrng_reg;
    logic             s1_end_reg;
    logic [PW-1:0]    s1_n_reg;
    logic             s1_over_reg;

    // Update stage
    logic             s2_valid_reg;
    logic [BIN_W-1:0] s2_v_reg;
    logic [AW-1:0]    s2_addr_reg;
    logic             s2_inrng_reg;
    logic             s2_end_reg;
    logic [PW-1:0]    s2_n_reg;
    logic             s2_over_reg;
    logic             s2_eq0_reg;
    logic             s2_eq1_reg;

    // Last memory write, for forwarding
    logic             lw_valid_reg;
    logic             lw_bank_reg;
    logic [AW-1:0]    lw_addr_reg;
    logic [BIN_W-1:0] lw_data_reg;

    // Column counters and decision state
    logic [PW-1:0]   bot_reg,  bot_next;
    logic            bmatch_reg, bmatch_next;
    logic [PW-1:0]   top_reg,  top_next;
    logic            seen_reg, seen_next;
    logic [DW-1:0]   pmag_reg, pmag_next;
    logic            pneg_reg, pneg_next;
    logic            rfull_reg, rfull_next;
    logic [PW-1:0]   rlen_reg, rlen_next;
    logic            rptr_reg, rptr_next;

    // Memory ports
    logic [BIN_W-1:0] rd_data0;
    logic [BIN_W-1:0] rd_data1;
    logic             wr_en;
    logic             wr_bank;

    // Forwarded reads
    logic [BIN_W-1:0] fwd0;
    logic [BIN_W-1:0] fwd1;
    logic             now_hit0, now_hit1, last_hit0, last_hit1;

    // Decision
    logic             eq_sel;
    logic [PW-1:0]    bot_upd, top_upd;
    logic             bmatch_upd;
    logic [CMPW-1:0]  h_ext, n_ext, quarter, run_ext, rlen_ext, count_full;
    logic [CODEW-1:0] col_dist, code_full;
    logic             top_sel, cand, ref_ok, trunc;
    logic [PW-1:0]    run;
    result_t          res;
    logic             push;

    // Result buffer
    result_t              head;
    logic                 head_valid;
    logic [FIFO_CW-1:0]   fifo_fill;
    logic [FIFO_CW-1:0]   in_flight;

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_on_reg <= 1'b1;
            height_reg  <= HEIGHT_DEFAULT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COMPRESSION_ON: comp_on_reg <= cfg_wdata[0];
                REG_COLUMN_HEIGHT:  height_reg  <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a word while the result buffer can absorb every column end in flight
    assign in_flight = FIFO_CW'(s1_valid_reg && s1_end_reg)
                     + FIFO_CW'(s2_valid_reg && s2_end_reg);
    assign s_tready  = (fifo_fill + in_flight) <= FIFO_CW'(FIFO_DEPTH - 1);
    assign acc       = s_tvalid && s_tready;
    assign in_rng    = pos_reg < PW'(MAX_BINS);
    assign pos_inc   = in_rng ? pos_reg + PW'(1) : pos_reg;

    // Track bin position and overflow of the arriving column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            over_reg <= 1'b0;
        end else if (acc) begin
            pos_reg  <= s_tlast ? '0 : pos_inc;
            over_reg <= s_tlast ? 1'b0 : (over_reg || !in_rng);
        end
    end

    // Both banks are read at the bin position; the update stage picks the reference
    ctc_col_mem #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    ) u_mem (
        .aclk     (aclk),
        .rd_en    (acc && in_rng),
        .rd_addr  (pos_reg[AW-1:0]),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_addr  (s2_addr_reg),
        .wr_data  (s2_v_reg)
    );

    // Compare stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
        end
        if (acc) begin
            s1_v_reg     <= s_tdata[BIN_W-1:0];
            s1_addr_reg  <= pos_reg[AW-1:0];
            s1_inrng_reg <= in_rng;
            s1_end_reg   <= s_tlast;
            s1_n_reg     <= pos_inc;
            s1_over_reg  <= over_reg || !in_rng;
        end
    end

    // Forward writes the read did not see: the one at the read edge and the one pending
    assign wr_en   = s2_valid_reg && s2_inrng_reg;
    assign wr_bank = !rptr_reg;

    assign now_hit0  = wr_en && !wr_bank && s1_inrng_reg && (s2_addr_reg == s1_addr_reg);
    assign now_hit1  = wr_en &&  wr_bank && s1_inrng_reg && (s2_addr_reg == s1_addr_reg);
    assign last_hit0 = lw_valid_reg && !lw_bank_reg && (lw_addr_reg == s1_addr_reg);
    assign last_hit1 = lw_valid_reg &&  lw_bank_reg && (lw_addr_reg == s1_addr_reg);

    assign fwd0 = now_hit0 ? s2_v_reg : (last_hit0 ? lw_data_reg : rd_data0);
    assign fwd1 = now_hit1 ? s2_v_reg : (last_hit1 ? lw_data_reg : rd_data1);

    // Update stage registers and the write record
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
            lw_valid_reg <= wr_en;
        end
        lw_bank_reg <= wr_bank;
        lw_addr_reg <= s2_addr_reg;
        lw_data_reg <= s2_v_reg;
        if (s1_valid_reg) begin
            s2_v_reg     <= s1_v_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_inrng_reg <= s1_inrng_reg;
            s2_end_reg   <= s1_end_reg;
            s2_n_reg     <= s1_n_reg;
            s2_over_reg  <= s1_over_reg;
            s2_eq0_reg   <= (fwd0 == s1_v_reg);
            s2_eq1_reg   <= (fwd1 == s1_v_reg);
        end
    end

    // Advance the match runs with this bin
    assign eq_sel = rptr_reg ? s2_eq1_reg : s2_eq0_reg;

    always_comb begin
        bot_upd    = bot_reg;
        bmatch_upd = bmatch_reg;
        top_upd    = top_reg;
        if (s2_valid_reg && s2_inrng_reg) begin
            if (bmatch_reg && eq_sel) begin
                bot_upd = bot_reg + PW'(1);
            end else begin
                bmatch_upd = 1'b0;
            end
            top_upd = eq_sel ? top_reg + PW'(1) : '0;
        end
    end

    // Decide how the finished column is stored
    assign h_ext    = CMPW'(height_reg);
    assign n_ext    = CMPW'(s2_n_reg);
    assign rlen_ext = CMPW'(rlen_reg);
    assign quarter  = h_ext >> 2;
    assign col_dist = CODEW'(pmag_reg) + CODEW'(1);
    assign top_sel  = (pmag_reg != '0) ? !pneg_reg : (top_upd > bot_upd);
    assign run      = top_sel ? top_upd : bot_upd;
    assign run_ext  = CMPW'(run);
    assign cand     = seen_reg && comp_on_reg && !s2_over_reg && (n_ext == h_ext);
    assign ref_ok   = rfull_reg && (rlen_ext == h_ext) && (col_dist <= CODEW'(MAX_DISTANCE));
    assign trunc    = cand && ref_ok && (run_ext > quarter);

    assign code_full  = trunc ? (top_sel ? col_dist : -col_dist) : '0;
    assign count_full = trunc ? h_ext - run_ext : n_ext;

    always_comb begin
        res.trunc_code  = code_full[CODE_W-1:0];
        res.keep_first  = (trunc && !top_sel) ? run_ext[CNT_W-1:0] : '0;
        res.keep_count  = count_full[CNT_W-1:0];
        res.over_length = s2_over_reg;
    end

    assign push = s2_valid_reg && s2_end_reg;

    // Next values of column and reference state
    always_comb begin
        bot_next    = bot_upd;
        bmatch_next = bmatch_upd;
        top_next    = top_upd;
        seen_next   = seen_reg;
        pmag_next   = pmag_reg;
        pneg_next   = pneg_reg;
        rfull_next  = rfull_reg;
        rlen_next   = rlen_reg;
        rptr_next   = rptr_reg;
        if (push) begin
            bot_next    = '0;
            bmatch_next = 1'b1;
            top_next    = '0;
            seen_next   = 1'b1;
            pmag_next   = trunc ? col_dist[DW-1:0] : '0;
            pneg_next   = trunc && !top_sel;
            if (!trunc) begin
                // Swap banks: the column just written becomes the reference
                rptr_next  = !rptr_reg;
                rlen_next  = s2_n_reg;
                rfull_next = !s2_over_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bot_reg    <= '0;
            bmatch_reg <= 1'b1;
            top_reg    <= '0;
            seen_reg   <= 1'b0;
            pmag_reg   <= '0;
            pneg_reg   <= 1'b0;
            rfull_reg  <= 1'b0;
            rlen_reg   <= '0;
            rptr_reg   <= 1'b0;
        end else begin
            bot_reg    <= bot_next;
            bmatch_reg <= bmatch_next;
            top_reg    <= top_next;
            seen_reg   <= seen_next;
            pmag_reg   <= pmag_next;
            pneg_reg   <= pneg_next;
            rfull_reg  <= rfull_next;
            rlen_reg   <= rlen_next;
            rptr_reg   <= rptr_next;
        end
    end

    // Hold results until the result channel takes them
    ctc_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .pop       (m_tready),
        .head_data (head),
        .not_empty (head_valid),
        .fill      (fifo_fill)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = M_TDATA_W'(head);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the column truncation compressor: streams columns, checks verdicts.
module tb;
    import ctc_pkg::*;

    localparam int BIN_LIMIT   = 1024;
    localparam int DIST_LIMIT  = 6;
    localparam int QUARTER     = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int SHOW_LIMIT  = 40;

    // How a queued column relates to the current bin pattern
    typedef enum int {
        COL_SAME, COL_NEW_BOTTOM, COL_NEW_TOP, COL_NEW_MID, COL_SCATTER, COL_FRESH
    } col_kind_e;

    // Result-side stall behavior
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKE} rx_mode_e;

    typedef struct packed {
        logic [BIN_W-1:0] data;
        logic             last;
    } bin_word_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [31:0] bin_value
    logic                  s_tlast   = 1'b0; // column_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [3:0] trunc_code, [14:4] keep_first, [25:15] keep_count, [26] over_length
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    column_truncation_compressor_unit #(
        .MAX_BINS     (BIN_LIMIT),
        .MAX_DISTANCE (DIST_LIMIT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Column tracking state of the checker
    logic [BIN_W-1:0] ref_bins [BIN_LIMIT];
    logic [BIN_W-1:0] cur_bins [BIN_LIMIT];
    bit               ref_full    = 1'b0;
    int unsigned      ref_len     = 0;
    bit               seen_column = 1'b0;
    int               last_code   = 0;
    int unsigned      bin_pos     = 0;
    int unsigned      bottom_run  = 0;
    bit               bottom_live = 1'b1;
    int unsigned      top_run     = 0;
    bit               overflow    = 1'b0;
    bit               comp_en     = 1'b1;
    int unsigned      height      = HEIGHT_DEFAULT;

    result_t          verdict_q [$];

    // Stimulus bookkeeping
    logic [BIN_W-1:0] pattern [BIN_LIMIT];
    bin_word_t        pending_q [$];
    int unsigned      bins_queued = 0;
    int unsigned      bins_taken  = 0;
    int unsigned      random_bins = 0;
    int unsigned      random_cols = 0;
    int               fail_count  = 0;
    bit               bin_taken   = 1'b0;
    bit               hold_req    = 1'b0;

    // Sender and receiver pacing
    int unsigned      burst_left = 1;
    int unsigned      gap_left   = 0;
    bit               hold_seen  = 1'b0;
    int unsigned      hold_left  = 0;
    int unsigned      rx_left    = 0;
    rx_mode_e         rx_mode    = RX_OPEN;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Fold one accepted bin into the column; on column end, queue the verdict
    function automatic void track_bin(input logic [BIN_W-1:0] value, input logic last);
        result_t     verdict;
        bit          match, top, whole;
        int          code;
        int unsigned col_dist, run, first, count, n;
        if (bin_pos < BIN_LIMIT) begin
            match = (value == ref_bins[bin_pos]);
            cur_bins[bin_pos] = value;
            if (bottom_live && match) bottom_run++;
            else bottom_live = 1'b0;
            top_run = match ? top_run + 1 : 0;
            bin_pos++;
        end else begin
            overflow = 1'b1;
        end
        if (!last) return;

        n     = bin_pos;
        whole = 1'b1;
        code  = 0;
        first = 0;
        count = n;
        if (seen_column && comp_en && !overflow && n == height) begin
            col_dist = ((last_code < 0) ? -last_code : last_code) + 1;
            top      = (last_code > 0);
            if (last_code == 0) top = (top_run > bottom_run);
            if (ref_full && ref_len == height && col_dist <= DIST_LIMIT) begin
                run = top ? top_run : bottom_run;
                if (run > height / QUARTER) begin
                    whole = 1'b0;
                    code  = top ? int'(col_dist) : -int'(col_dist);
                    first = top ? 0 : run;
                    count = height - run;
                end
            end
        end

        // A column kept whole becomes the new reference
        if (whole) begin
            for (int i = 0; i < BIN_LIMIT; i++) ref_bins[i] = cur_bins[i];
            ref_len  = n;
            ref_full = !overflow;
            code     = 0;
            first    = 0;
            count    = n;
        end

        verdict.trunc_code  = code[CODE_W-1:0];
        verdict.keep_first  = first[CNT_W-1:0];
        verdict.keep_count  = count[CNT_W-1:0];
        verdict.over_length = overflow;
        verdict_q.insert(verdict_q.size(), verdict);

        last_code   = code;
        seen_column = 1'b1;
        bin_pos     = 0;
        bottom_run  = 0;
        bottom_live = 1'b1;
        top_run     = 0;
        overflow    = 1'b0;
    endfunction

    function automatic void flag_field(input string field, input logic signed [31:0] want,
                                       input logic signed [31:0] seen);
        if (fail_count < SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
        fail_count++;
    endfunction

    // Compare one result word against the oldest pending verdict
    function automatic void check_verdict(input logic [M_TDATA_W-1:0] word);
        result_t seen, want;
        seen = word[$bits(result_t)-1:0];
        if (verdict_q.size() == 0) begin
            if (fail_count < SHOW_LIMIT)
                $display("%0t: result with none pending, expected nothing, got %0h",
                         $time, word);
            fail_count++;
            return;
        end
        want = verdict_q.pop_front();
        if (seen.trunc_code !== want.trunc_code)
            flag_field("trunc_code", $signed(want.trunc_code), $signed(seen.trunc_code));
        if (seen.keep_first !== want.keep_first)
            flag_field("keep_first", want.keep_first, seen.keep_first);
        if (seen.keep_count !== want.keep_count)
            flag_field("keep_count", want.keep_count, seen.keep_count);
        if (seen.over_length !== want.over_length)
            flag_field("over_length", want.over_length, seen.over_length);
    endfunction

    // Sample both handshakes at the rising edge
    always @(posedge aclk) begin
        bin_taken = aresetn && s_tvalid && s_tready;
        if (bin_taken) begin
            track_bin(s_tdata, s_tlast);
            bins_taken++;
        end
        if (aresetn && m_tvalid && m_tready) check_verdict(m_tdata);
    end

    // Offer queued bins in bursts separated by random gaps
    always @(negedge aclk) begin : feed_bins
        bin_word_t word;
        if (!s_tvalid || bin_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                word = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= word.data;
                s_tlast  <= word.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20)
                                                             : $urandom_range(0, 3);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side: one long hold on request, otherwise shifting patterns
    always @(negedge aclk) begin : pace_results
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 256);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                default:   m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (index == REG_COMPRESSION_ON) comp_en = data[0];
        else height = data;
    endtask

    // Hold until every bin is in and every verdict is out, then let the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        while (bins_taken != bins_queued || verdict_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Queue one column derived from the running bin pattern
    task automatic queue_column(input int unsigned len, input col_kind_e kind);
        int unsigned      span, lo, idx, i;
        logic [BIN_W-1:0] word_value;
        bit               hit;
        bin_word_t        entry;
        span = $urandom_range(1, (len > 1) ? len / 2 : 1);
        case (kind)
            COL_NEW_TOP: lo = len - span;
            COL_NEW_MID: lo = $urandom_range(0, len - 1);
            default:     lo = 0;
        endcase
        for (i = 0; i < len; i++) begin
            idx        = (i < BIN_LIMIT) ? i : BIN_LIMIT - 1;
            word_value = pattern[idx];
            case (kind)
                COL_NEW_BOTTOM, COL_NEW_TOP, COL_NEW_MID: hit = (i >= lo && i < lo + span);
                COL_SCATTER: hit = ($urandom_range(0, 7) == 0);
                COL_FRESH:   hit = 1'b1;
                default:     hit = 1'b0;
            endcase
            // Either a fresh word or a single flipped bit
            if (hit)
                word_value = ($urandom_range(0, 1) != 0) ? $urandom()
                           : word_value ^ (32'h1 << $urandom_range(0, 31));
            if (kind == COL_FRESH && i < BIN_LIMIT) pattern[i] = word_value;
            entry.data = word_value;
            entry.last = (i == len - 1);
            pending_q.insert(pending_q.size(), entry);
            bins_queued++;
        end
    endtask

    function automatic int unsigned pick_len(input int unsigned h);
        if (h < 1 || h > BIN_LIMIT) return $urandom_range(1, 12);
        if ($urandom_range(0, 11) != 0) return h;
        return $urandom_range(1, h + 3);
    endfunction

    function automatic col_kind_e pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return COL_SAME;
        if (roll < 45) return COL_NEW_BOTTOM;
        if (roll < 70) return COL_NEW_TOP;
        if (roll < 80) return COL_NEW_MID;
        if (roll < 90) return COL_SCATTER;
        return COL_FRESH;
    endfunction

    // One random phase: configure while idle, stream columns, drain
    task automatic random_phase(input int unsigned h, input bit comp, input int unsigned cols);
        int unsigned len, c;
        if ($urandom_range(0, 1) != 0) begin
            write_reg(REG_COLUMN_HEIGHT, h[CFG_DATA_W-1:0]);
            write_reg(REG_COMPRESSION_ON, {10'($urandom()), comp});
        end else begin
            write_reg(REG_COMPRESSION_ON, {10'($urandom()), comp});
            write_reg(REG_COLUMN_HEIGHT, h[CFG_DATA_W-1:0]);
        end
        @(posedge aclk);
        for (c = 0; c < cols; c++) begin
            len = pick_len(h);
            queue_column(len, pick_kind());
            random_bins += len;
            random_cols++;
        end
        wait_idle();
    endtask

    initial begin : stimulus
        int unsigned h, roll;
        for (int i = 0; i < BIN_LIMIT; i++) begin
            ref_bins[i] = '0;
            cur_bins[i] = '0;
            pattern[i]  = $urandom();
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings; short columns miss the default height and stay whole
        @(posedge aclk);
        queue_column(6, COL_FRESH);
        queue_column(3, COL_SAME);
        wait_idle();

        // Distance chain past its limit, then a top-dropped chain and a broken one
        write_reg(REG_COLUMN_HEIGHT, 11'd4);
        @(posedge aclk);
        queue_column(4, COL_FRESH);
        repeat (7) queue_column(4, COL_SAME);
        queue_column(4, COL_NEW_BOTTOM);
        queue_column(4, COL_NEW_BOTTOM);
        queue_column(4, COL_NEW_TOP);
        wait_idle();

        // Single-bin columns and a wrong-size one
        write_reg(REG_COLUMN_HEIGHT, 11'd1);
        @(posedge aclk);
        queue_column(1, COL_FRESH);
        queue_column(1, COL_SAME);
        queue_column(2, COL_SAME);
        wait_idle();

        // Compression off keeps identical columns whole
        write_reg(REG_COMPRESSION_ON, 11'h7FE);
        write_reg(REG_COLUMN_HEIGHT, 11'd4);
        @(posedge aclk);
        queue_column(4, COL_SAME);
        queue_column(4, COL_SAME);
        wait_idle();

        // Heights that no column can meet
        write_reg(REG_COMPRESSION_ON, 11'h001);
        write_reg(REG_COLUMN_HEIGHT, 11'd0);
        @(posedge aclk);
        queue_column(1, COL_SAME);
        queue_column(3, COL_SAME);
        wait_idle();
        write_reg(REG_COLUMN_HEIGHT, 11'h7FF);
        @(posedge aclk);
        queue_column(5, COL_SAME);
        wait_idle();

        // Long result stall while the sender keeps offering bins
        @(posedge aclk);
        hold_req = 1'b1;
        random_phase(8, 1'b1, 16);

        while (random_bins < 580 || random_cols < 40) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) h = 1;
            else if (roll == 1) h = $urandom_range(33, 128);
            else h = $urandom_range(2, 24);
            random_phase(h, ($urandom_range(0, 6) != 0), $urandom_range(4, 14));
        end

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
